// ===== design/rgb_median_3x3_filter_top_macros.svh =====
// Assertion helpers shared by the filter modules.
`ifndef RGB_MEDIAN_3X3_FILTER_TOP_MACROS_SVH
`define RGB_MEDIAN_3X3_FILTER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RMF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rmf_pkg.sv =====
`default_nettype none
package rmf_pkg;

    localparam int IN_DATA_W           = 24;
    localparam int OUT_DATA_W          = 48;
    localparam int ROW_W               = 12;
    localparam int OUT_COL_W           = 10;
    localparam int CFG_DATA_W          = 12;
    localparam int CFG_IDX_W           = 1;
    localparam int WIDTH_REG_W         = 11;
    localparam int NUM_RES             = 4;
    localparam int WINDOW_SIZE         = 9;
    localparam int DEFAULT_MAX_WIDTH   = 1024;
    localparam int DEFAULT_QUEUE_DEPTH = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [ROW_W-1:0]       HEIGHT_RESET = 12'd480;

    // pixel as {blue, green, red}, red in the low byte
    typedef logic [IN_DATA_W-1:0] pix_t;

    // one window position; mask bit k marks result k of the item
    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic [NUM_RES-1:0]   mask;
        pix_t                 v;
        pix_t                 p5;
        pix_t                 p7;
        pix_t                 pix;
    } queue_entry_t;

endpackage
`default_nettype wire

// ===== design/rmf_ram.sv =====
`default_nettype none
module rmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

// ===== design/rmf_front.sv =====
`default_nettype none
`include "rgb_median_3x3_filter_top_macros.svh"
module rmf_front #(
    parameter int MAX_WIDTH   = 1024,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [rmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rmf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  wire logic [rmf_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_count,
    output logic                                     q_push,
    output rmf_pkg::queue_entry_t                    q_din
);
    import rmf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [CW-1:0]      col;
        logic [NUM_RES-1:0] mask;
        logic               use_med;
    } ctl_t;

    typedef logic [7:0] byte_t;

    function automatic byte_t max2(input byte_t a, input byte_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic byte_t min2(input byte_t a, input byte_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic byte_t med3(input byte_t a, input byte_t b, input byte_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // {hi, mid, lo}
    function automatic logic [23:0] sort3(input byte_t a, input byte_t b, input byte_t c);
        byte_t lo;
        byte_t hi;
        lo = min2(a, b);
        hi = max2(a, b);
        return {max2(hi, c), med3(a, b, c), min2(lo, c)};
    endfunction

    logic [WIDTH_REG_W-1:0] width_reg;
    logic [ROW_W-1:0]       height_reg;
    logic [CW-1:0]          col_count_reg;
    logic [ROW_W-1:0]       row_count_reg;

    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic             col_last;
    logic             row_last;
    logic             accept;
    ctl_t             ctl_next;

    logic  a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    ctl_t  a_ctl_reg, b_ctl_reg, c_ctl_reg, d_ctl_reg;
    pix_t  a_pix_reg;
    pix_t  window_reg [WINDOW_SIZE];
    pix_t  upper_rdata, lower_rdata;
    byte_t c_sort_reg [3][3][3];
    pix_t  c_keep_reg [4];
    byte_t d_trip_reg [3][3];
    pix_t  d_keep_reg [4];
    pix_t  med_pix;

    always_comb
    begin
        if (width_reg < 11'd3)
        begin
            w_eff = WW'(3);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        h_eff    = (height_reg < 12'd3) ? 12'd3 : height_reg;
        col_last = (WW'(col_count_reg) == (w_eff - WW'(1)));
        row_last = (row_count_reg == (h_eff - 12'd1));

        ctl_next.row     = row_count_reg;
        ctl_next.col     = col_count_reg;
        ctl_next.mask[0] = (row_count_reg != '0) && (col_count_reg != '0);
        ctl_next.mask[1] = (row_count_reg != '0) && col_last;
        ctl_next.mask[2] = row_last && (col_count_reg != '0);
        ctl_next.mask[3] = row_last && col_last;
        ctl_next.use_med = (row_count_reg >= 12'd2) && (col_count_reg >= CW'(2));
    end

    // credit: every item in flight has a queue slot reserved
    assign s_axis_tready = (32'(q_count) + 32'(a_valid_reg) + 32'(b_valid_reg)
                            + 32'(c_valid_reg) + 32'(d_valid_reg)) < QUEUE_DEPTH;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default:          height_reg <= cfg_wdata;
            endcase
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_count_reg <= '0;
                row_count_reg <= row_last ? '0 : row_count_reg + 12'd1;
            end
            else
            begin
                col_count_reg <= col_count_reg + CW'(1);
            end
        end
    end

    rmf_ram #(.WIDTH(IN_DATA_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (a_valid_reg),
        .waddr (a_ctl_reg.col),
        .wdata (lower_rdata),
        .raddr (col_count_reg),
        .rdata (upper_rdata)
    );

    rmf_ram #(.WIDTH(IN_DATA_W), .DEPTH(MAX_WIDTH)) u_lower (
        .clk   (clk),
        .we    (a_valid_reg),
        .waddr (a_ctl_reg.col),
        .wdata (a_pix_reg),
        .raddr (col_count_reg),
        .rdata (lower_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_SIZE; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            if (a_valid_reg)
            begin
                // shift one column left, new column from the line stores and the new pixel
                for (int k = 0; k < 3; k++)
                begin
                    window_reg[k*3]   <= window_reg[k*3+1];
                    window_reg[k*3+1] <= window_reg[k*3+2];
                end
                window_reg[2] <= upper_rdata;
                window_reg[5] <= lower_rdata;
                window_reg[8] <= a_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_ctl_reg <= ctl_next;
        a_pix_reg <= s_axis_tdata;
        b_ctl_reg <= a_ctl_reg;
        c_ctl_reg <= b_ctl_reg;
        d_ctl_reg <= c_ctl_reg;
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int col = 0; col < 3; col++)
            begin
                {c_sort_reg[ch][col][2], c_sort_reg[ch][col][1], c_sort_reg[ch][col][0]} <=
                    sort3(window_reg[col][ch*8 +: 8], window_reg[col+3][ch*8 +: 8],
                          window_reg[col+6][ch*8 +: 8]);
            end
            d_trip_reg[ch][0] <= max2(max2(c_sort_reg[ch][0][0], c_sort_reg[ch][1][0]),
                                      c_sort_reg[ch][2][0]);
            d_trip_reg[ch][1] <= med3(c_sort_reg[ch][0][1], c_sort_reg[ch][1][1],
                                      c_sort_reg[ch][2][1]);
            d_trip_reg[ch][2] <= min2(min2(c_sort_reg[ch][0][2], c_sort_reg[ch][1][2]),
                                      c_sort_reg[ch][2][2]);
        end
        c_keep_reg[0] <= window_reg[4];
        c_keep_reg[1] <= window_reg[5];
        c_keep_reg[2] <= window_reg[7];
        c_keep_reg[3] <= window_reg[8];
        d_keep_reg    <= c_keep_reg;
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            med_pix[ch*8 +: 8] = med3(d_trip_reg[ch][0], d_trip_reg[ch][1], d_trip_reg[ch][2]);
        end
        q_din.row  = d_ctl_reg.row;
        q_din.col  = OUT_COL_W'(d_ctl_reg.col);
        q_din.mask = d_ctl_reg.mask;
        q_din.v    = d_ctl_reg.use_med ? med_pix : d_keep_reg[0];
        q_din.p5   = d_keep_reg[1];
        q_din.p7   = d_keep_reg[2];
        q_din.pix  = d_keep_reg[3];
    end

    // drop items that produce no result
    assign q_push = d_valid_reg && (d_ctl_reg.mask != '0);

    `RMF_ASSERT_IMP(a_credit, 1'b1, (32'(q_count) + 32'(a_valid_reg) + 32'(b_valid_reg) + 32'(c_valid_reg) + 32'(d_valid_reg)) <= QUEUE_DEPTH, "front credit exceeded")
    `RMF_ASSERT_NEXT(a_pipe_moves, a_valid_reg && !cfg_we, b_valid_reg, "front pipeline lost an item")
endmodule
`default_nettype wire

// ===== design/rmf_queue.sv =====
`default_nettype none
`include "rgb_median_3x3_filter_top_macros.svh"
module rmf_queue #(
    parameter int DEPTH = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire rmf_pkg::queue_entry_t         din,
    input  wire logic                          pop,
    output rmf_pkg::queue_entry_t              dout,
    output logic                               not_empty,
    output logic [$clog2(DEPTH+1)-1:0]         count
);
    import rmf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    queue_entry_t               mem_reg [DEPTH];
    logic [PW-1:0]              wr_ptr_reg, rd_ptr_reg;
    logic [$clog2(DEPTH+1)-1:0] count_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (32'(p) == DEPTH - 1) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    `RMF_ASSERT_IMP(a_no_overflow, push && !pop, 32'(count_reg) < DEPTH, "queue overflow")
    `RMF_ASSERT_IMP(a_no_underflow, pop, count_reg != '0, "queue underflow")
endmodule
`default_nettype wire

// ===== design/rmf_back.sv =====
`default_nettype none
`include "rgb_median_3x3_filter_top_macros.svh"
module rmf_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rmf_pkg::queue_entry_t            head,
    input  wire logic                             head_valid,
    output logic                                  pop,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // out_row [11:0], out_col [21:12], red [29:22], green [37:30], blue [45:38]
    output logic [rmf_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // last_of_run
    output logic                                  m_axis_tlast,
    // frame_done
    output logic                                  m_axis_tuser
);
    import rmf_pkg::*;

    logic [NUM_RES-1:0]   sent_reg;
    logic [NUM_RES-1:0]   remaining, sel, after;
    logic                 load;
    logic [ROW_W-1:0]     row_sel;
    logic [OUT_COL_W-1:0] col_sel;
    pix_t                 pix_sel;
    logic                 valid_reg, last_reg, user_reg;
    logic [OUT_DATA_W-1:0] data_reg;

    always_comb
    begin
        remaining = head.mask & ~sent_reg;
        sel       = remaining & (~remaining + 1'b1);
        after     = remaining & ~sel;
        case (sel)
            4'b0001:
            begin
                row_sel = head.row - 12'd1;
                col_sel = head.col - 10'd1;
                pix_sel = head.v;
            end
            4'b0010:
            begin
                row_sel = head.row - 12'd1;
                col_sel = head.col;
                pix_sel = head.p5;
            end
            4'b0100:
            begin
                row_sel = head.row;
                col_sel = head.col - 10'd1;
                pix_sel = head.p7;
            end
            default:
            begin
                row_sel = head.row;
                col_sel = head.col;
                pix_sel = head.pix;
            end
        endcase
    end

    assign load = head_valid && (!valid_reg || m_axis_tready);
    assign pop  = load && (after == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sent_reg  <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                sent_reg  <= (after == '0) ? '0 : (sent_reg | sel);
            end
            else if (m_axis_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {2'b00, pix_sel[23:16], pix_sel[15:8], pix_sel[7:0], col_sel, row_sel};
            last_reg <= (after == '0);
            user_reg <= sel[NUM_RES-1];
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = user_reg;

    `RMF_ASSERT_IMP(a_done_is_last, valid_reg && user_reg, last_reg, "frame_done without last_of_run")
endmodule
`default_nettype wire

// ===== design/rgb_median_3x3_filter_top.sv =====
// 3x3 median filter for a raster-order RGB stream, 8 bits per channel.
// Input channel s_axis: one pixel per item, accepted on tvalid && tready.
// Output channel m_axis: one result per item carrying its row and column;
// tlast marks the last result caused by an input pixel, tuser the final
// pixel of the frame. Results trail the input by one row and one column.
// Configuration: cfg_we with cfg_index 0 = image width, 1 = image height;
// each write restarts the frame. Write only while the block is idle.
// A pixel passes pipeline stages a to d, the queue and the output register
// before its result is on m_axis. Throughput: one pixel per clock while
// the queue has room, set by one line store read and one write per clock
// and the one-result-per-clock output register; on the last row each pixel
// yields two results, so the input rate halves there.
// The input side keeps one queue slot reserved for each pixel in the
// median pipeline; when the receiver stalls, the queue fills and tready
// drops. Reset clears counters, pipeline and queue; width returns to 640
// and height to 480. Line stores are not cleared and need no sweep.
`default_nettype none
module rgb_median_3x3_filter_top #(
    parameter int MAX_WIDTH   = rmf_pkg::DEFAULT_MAX_WIDTH,
    parameter int QUEUE_DEPTH = rmf_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [rmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rmf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  wire logic [rmf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // out_row [11:0], out_col [21:12], red_out [29:22], green_out [37:30],
    // blue_out [45:38]
    output logic [rmf_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // last_of_run
    output logic                                  m_axis_tlast,
    // frame_done
    output logic                                  m_axis_tuser
);
    import rmf_pkg::*;

    queue_entry_t                     q_din, q_dout;
    logic                             q_push, q_pop, q_not_empty;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    rmf_front #(.MAX_WIDTH(MAX_WIDTH), .QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_count       (q_count),
        .q_push        (q_push),
        .q_din         (q_din)
    );

    rmf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .din       (q_din),
        .pop       (q_pop),
        .dout      (q_dout),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    rmf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_dout),
        .head_valid    (q_not_empty),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );
endmodule
`default_nettype wire
